// ===== rtl/bas_pkg.sv =====
// Shared types, widths and helper functions for the bearing and avoidance steering block.
package bas_pkg;

  // Fixed datapath widths (independent of coordinate width)
  localparam int RAD_W      = 64;  // scaled squared length fed to the root chain
  localparam int REM_W      = 34;  // root partial remainder
  localparam int ROOT_W     = 32;  // vector length, 15+ fraction bits
  localparam int NUM_W      = 54;  // cosine dividend
  localparam int QUO_W      = 24;  // cosine quotient, unsigned Q8.16
  localparam int DREM_W     = 32;  // divider partial remainder
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 24;
  localparam int ANG_W      = 10;  // angles 0..719 in intermediate math

  localparam logic [QUO_W-1:0] COS_MAX = 24'd6553600;  // 100.0 in Q8.16
  localparam logic [QUO_W-1:0] SEG1    = 24'd3932160;  // 60.0
  localparam logic [QUO_W-1:0] SEG2    = 24'd5898240;  // 90.0
  localparam logic [QUO_W-1:0] SEG3    = 24'd6488064;  // 99.0

  localparam logic [ANG_W-1:0] DEG_90  = 10'd90;
  localparam logic [ANG_W-1:0] DEG_180 = 10'd180;
  localparam logic [ANG_W-1:0] DEG_270 = 10'd270;
  localparam logic [ANG_W-1:0] DEG_360 = 10'd360;

  // Per-item side information that travels with the datapath
  typedef struct packed {
    logic       action;
    logic [8:0] heading;
    logic       dx_neg;
    logic       dz_neg;
    logic       zero;
  } side_t;

  // Floor of v/5, exact for v below 1024
  function automatic logic [7:0] div5(input logic [9:0] v);
    logic [17:0] p;
    begin
      p = 18'(v) * 18'd205;
      div5 = p[17:10];
    end
  endfunction

  // Angle c lies on the arc from a to b
  function automatic logic in_arc(input logic [ANG_W-1:0] a, input logic [ANG_W-1:0] b,
                                  input logic [ANG_W-1:0] c);
    begin
      if (a < b) in_arc = (c >= a) && (b >= c);
      else       in_arc = (b >= c) || ((c >= a) && (c <= DEG_360));
    end
  endfunction

  // Add an offset below 360 and wrap once
  function automatic logic [ANG_W-1:0] wrap_add(input logic [ANG_W-1:0] a,
                                                input logic [ANG_W-1:0] b);
    logic [ANG_W-1:0] s;
    begin
      s = a + b;
      wrap_add = (s >= DEG_360) ? s - DEG_360 : s;
    end
  endfunction

endpackage

// ===== rtl/bas_front.sv =====
// Front stages: offset vector, magnitudes, squares and the root/divider operands.
module bas_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         action,
  input  logic [COORD_BITS-1:0]        target_x,
  input  logic [COORD_BITS-1:0]        target_z,
  input  logic [COORD_BITS-1:0]        robot_x,
  input  logic [COORD_BITS-1:0]        robot_z,
  input  logic [8:0]                   heading,
  output logic                         out_valid,
  output bas_pkg::side_t               out_side,
  output logic [bas_pkg::RAD_W-1:0]    out_rad,
  output logic [bas_pkg::NUM_W-1:0]    out_num
);

  localparam int CB     = COORD_BITS;
  localparam int NPW    = CB + 7;
  localparam int RAD_SH = 62 - 2 * CB;
  localparam int NUM_SH = 47 - CB;

  logic signed [CB:0] dx, dz;
  logic        [CB:0] dx_abs, dz_abs;
  logic        [8:0]  h_red;

  logic               v1, v2;
  bas_pkg::side_t     side1, side2;
  logic [CB-1:0]      adx1, adz1;
  logic [2*CB-1:0]    sqx2, sqz2;
  logic [NPW-1:0]     np2;
  logic [2*CB:0]      ssum;

  // Form the offset vector and its magnitudes
  always_comb begin
    dx     = $signed({target_x[CB-1], target_x}) - $signed({robot_x[CB-1], robot_x});
    dz     = $signed({target_z[CB-1], target_z}) - $signed({robot_z[CB-1], robot_z});
    dx_abs = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
    dz_abs = dz[CB] ? (CB+1)'(-dz) : (CB+1)'(dz);
    h_red  = (heading >= 9'd360) ? heading - 9'd360 : heading;
  end

  // Stage one: magnitudes and flags
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    side1.action  <= action;
    side1.heading <= h_red;
    side1.dx_neg  <= dx[CB];
    side1.dz_neg  <= dz[CB];
    side1.zero    <= (dx == '0) && (dz == '0);
    adx1          <= dx_abs[CB-1:0];
    adz1          <= dz_abs[CB-1:0];
  end

  // Stage two: squares and scaled numerator
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    side2 <= side1;
    sqx2  <= (2*CB)'(adx1) * (2*CB)'(adx1);
    sqz2  <= (2*CB)'(adz1) * (2*CB)'(adz1);
    np2   <= NPW'(adz1) * NPW'(100);
  end

  assign ssum = {1'b0, sqx2} + {1'b0, sqz2};

  // Stage three: align operands for the root and divider chains
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= v2;
    out_side <= side2;
    out_rad  <= bas_pkg::RAD_W'(ssum) << RAD_SH;
    out_num  <= bas_pkg::NUM_W'(np2) << NUM_SH;
  end

endmodule

// ===== rtl/bas_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per cycle.
module bas_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  bas_pkg::side_t                in_side,
  input  logic [bas_pkg::RAD_W-1:0]     in_rad,
  input  logic [bas_pkg::REM_W-1:0]     in_rem,
  input  logic [bas_pkg::ROOT_W-1:0]    in_root,
  input  logic [bas_pkg::NUM_W-1:0]     in_num,
  output logic                          out_valid,
  output bas_pkg::side_t                out_side,
  output logic [bas_pkg::RAD_W-1:0]     out_rad,
  output logic [bas_pkg::REM_W-1:0]     out_rem,
  output logic [bas_pkg::ROOT_W-1:0]    out_root,
  output logic [bas_pkg::NUM_W-1:0]     out_num
);

  logic [bas_pkg::REM_W+1:0] cur, trial;
  logic                      ge;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    cur   = {in_rem, in_rad[bas_pkg::RAD_W-1 -: 2]};
    trial = (bas_pkg::REM_W+2)'({in_root, 2'b01});
    ge    = cur >= trial;
  end

  // Advance to the neighbor cell
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
    out_side <= in_side;
    out_rad  <= in_rad << 2;
    out_rem  <= ge ? bas_pkg::REM_W'(cur - trial) : bas_pkg::REM_W'(cur);
    out_root <= {in_root[bas_pkg::ROOT_W-2:0], ge};
    out_num  <= in_num;
  end

endmodule

// ===== rtl/bas_div_cell.sv =====
// One cell of the restoring divider chain: resolves one quotient bit per cycle.
module bas_div_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  bas_pkg::side_t                in_side,
  input  logic [bas_pkg::DREM_W-1:0]    in_rem,
  input  logic [bas_pkg::QUO_W-1:0]     in_dvd,
  input  logic [bas_pkg::QUO_W-1:0]     in_quo,
  input  logic [bas_pkg::ROOT_W-1:0]    in_len,
  output logic                          out_valid,
  output bas_pkg::side_t                out_side,
  output logic [bas_pkg::DREM_W-1:0]    out_rem,
  output logic [bas_pkg::QUO_W-1:0]     out_dvd,
  output logic [bas_pkg::QUO_W-1:0]     out_quo,
  output logic [bas_pkg::ROOT_W-1:0]    out_len
);

  logic [bas_pkg::DREM_W:0] cur, dif;
  logic                     ge;

  // Shift in one dividend bit and compare against the length
  always_comb begin
    cur = {in_rem, in_dvd[bas_pkg::QUO_W-1]};
    dif = cur - {1'b0, in_len};
    ge  = cur >= {1'b0, in_len};
  end

  // Advance to the neighbor cell
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
    out_side <= in_side;
    out_rem  <= ge ? dif[bas_pkg::DREM_W-1:0] : cur[bas_pkg::DREM_W-1:0];
    out_dvd  <= in_dvd << 1;
    out_quo  <= {in_quo[bas_pkg::QUO_W-2:0], ge};
    out_len  <= in_len;
  end

endmodule

// ===== rtl/bas_back.sv =====
// Back stages: arccos line fit, quadrant mirroring and steering decision.
module bas_back #(
  parameter int AVOID_OFFSET = 85
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  bas_pkg::side_t             in_side,
  input  logic [bas_pkg::QUO_W-1:0]  in_quo,
  output logic                       done,
  output logic                       turn,
  output logic [8:0]                 steer_angle,
  output logic [8:0]                 bearing
);

  localparam logic [bas_pkg::ANG_W-1:0] OFF = bas_pkg::ANG_W'(AVOID_OFFSET);
  localparam logic [bas_pkg::ANG_W-1:0] OFF_L = bas_pkg::ANG_W'(360 - AVOID_OFFSET);

  logic [bas_pkg::QUO_W-1:0]   c;
  logic [31:0]                 x1, x2, x3, x4;
  logic [6:0]                  fit;
  logic                        v1;
  bas_pkg::side_t              side1;
  logic [6:0]                  fit1;
  logic [bas_pkg::ANG_W-1:0]   ang, h, h90, h180, h270, steer;
  logic                        t;

  // Saturate the cosine and evaluate the four line segments
  always_comb begin
    c  = (in_quo > bas_pkg::COS_MAX) ? bas_pkg::COS_MAX : in_quo;
    x1 = 32'd29491200 - 32'(c) * 32'd3;
    x2 = 32'd35389440 - (32'(c) - 32'(bas_pkg::SEG1)) * 32'd9;
    x3 = 32'd1769472  - (32'(c) - 32'(bas_pkg::SEG2)) * 32'd2;
    x4 = 32'd589824   - (32'(c) - 32'(bas_pkg::SEG3)) * 32'd9;
    if (c < bas_pkg::SEG1)      fit = 7'(bas_pkg::div5(x1[25:16]));
    else if (c < bas_pkg::SEG2) fit = 7'(bas_pkg::div5({1'b0, x2[25:17]}));
    else if (c < bas_pkg::SEG3) fit = x3[22:16];
    else                        fit = x4[22:16];
  end

  // Hold the fitted angle
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    side1 <= in_side;
    fit1  <= fit;
  end

  // Mirror into the quadrant and decide the steering
  always_comb begin
    ang = bas_pkg::ANG_W'(fit1);
    if (side1.dz_neg) ang = bas_pkg::DEG_180 - ang;
    if (side1.dx_neg) ang = bas_pkg::DEG_360 - ang;
    if (side1.zero)   ang = '0;
    h    = bas_pkg::ANG_W'(side1.heading);
    h90  = bas_pkg::wrap_add(h, bas_pkg::DEG_90);
    h180 = bas_pkg::wrap_add(h, bas_pkg::DEG_180);
    h270 = bas_pkg::wrap_add(h, bas_pkg::DEG_270);
    if (!side1.action) begin
      t     = 1'b1;
      steer = ang;
    end else if (!(bas_pkg::in_arc(h, h90, ang) || bas_pkg::in_arc(h270, h, ang))) begin
      t     = 1'b0;
      steer = h;
    end else begin
      t = 1'b1;
      if (bas_pkg::in_arc(h, h180, ang)) steer = bas_pkg::wrap_add(ang, OFF_L);
      else                               steer = bas_pkg::wrap_add(ang, OFF);
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v1;
    turn        <= t;
    steer_angle <= steer[8:0];
    bearing     <= ang[8:0];
  end

endmodule

// ===== rtl/bearing_and_avoidance_steering.sv =====
// Top level: front stages, square root cell chain, divider cell chain, back stages.
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------------
//  command  | start / busy     | action, target_x, target_z, robot_x, robot_z, heading
//  result   | done (strobe)    | turn, steer_angle, bearing
//
// One command per cycle; busy stays low. Each result passes through the pipeline:
// 3 front stages, 32 root cells, 24 divider cells, 2 back stages.
// Reset clears every valid bit; payload registers are not reset.
// The receiver cannot stall: a result is on the ports for one cycle only.
module bearing_and_avoidance_steering #(
  parameter int COORD_BITS   = 16,
  parameter int AVOID_OFFSET = 85
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action,
  input  logic [COORD_BITS-1:0] target_x,
  input  logic [COORD_BITS-1:0] target_z,
  input  logic [COORD_BITS-1:0] robot_x,
  input  logic [COORD_BITS-1:0] robot_z,
  input  logic [8:0]            heading,
  output logic                  done,
  output logic                  turn,
  output logic [8:0]            steer_angle,
  output logic [8:0]            bearing
);

  localparam int NS = bas_pkg::SQRT_STEPS;
  localparam int ND = bas_pkg::DIV_STEPS;

  logic                          s_v    [NS+1];
  bas_pkg::side_t                s_side [NS+1];
  logic [bas_pkg::RAD_W-1:0]     s_rad  [NS+1];
  logic [bas_pkg::REM_W-1:0]     s_rem  [NS+1];
  logic [bas_pkg::ROOT_W-1:0]    s_root [NS+1];
  logic [bas_pkg::NUM_W-1:0]     s_num  [NS+1];

  logic                          d_v    [ND+1];
  bas_pkg::side_t                d_side [ND+1];
  logic [bas_pkg::DREM_W-1:0]    d_rem  [ND+1];
  logic [bas_pkg::QUO_W-1:0]     d_dvd  [ND+1];
  logic [bas_pkg::QUO_W-1:0]     d_quo  [ND+1];
  logic [bas_pkg::ROOT_W-1:0]    d_len  [ND+1];

  assign busy = 1'b0;

  bas_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .action    (action),
    .target_x  (target_x),
    .target_z  (target_z),
    .robot_x   (robot_x),
    .robot_z   (robot_z),
    .heading   (heading),
    .out_valid (s_v[0]),
    .out_side  (s_side[0]),
    .out_rad   (s_rad[0]),
    .out_num   (s_num[0])
  );

  assign s_rem[0]  = '0;
  assign s_root[0] = '0;

  // Root chain: one bit per cell
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    bas_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (s_v[i]),
      .in_side   (s_side[i]),
      .in_rad    (s_rad[i]),
      .in_rem    (s_rem[i]),
      .in_root   (s_root[i]),
      .in_num    (s_num[i]),
      .out_valid (s_v[i+1]),
      .out_side  (s_side[i+1]),
      .out_rad   (s_rad[i+1]),
      .out_rem   (s_rem[i+1]),
      .out_root  (s_root[i+1]),
      .out_num   (s_num[i+1])
    );
  end

  // Split the dividend: high part seeds the remainder, low part feeds the cells
  assign d_v[0]    = s_v[NS];
  assign d_side[0] = s_side[NS];
  assign d_rem[0]  = bas_pkg::DREM_W'(s_num[NS][bas_pkg::NUM_W-1:bas_pkg::QUO_W]);
  assign d_dvd[0]  = s_num[NS][bas_pkg::QUO_W-1:0];
  assign d_quo[0]  = '0;
  assign d_len[0]  = s_root[NS];

  // Divider chain: one quotient bit per cell
  for (genvar j = 0; j < ND; j++) begin : g_div
    bas_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (d_v[j]),
      .in_side   (d_side[j]),
      .in_rem    (d_rem[j]),
      .in_dvd    (d_dvd[j]),
      .in_quo    (d_quo[j]),
      .in_len    (d_len[j]),
      .out_valid (d_v[j+1]),
      .out_side  (d_side[j+1]),
      .out_rem   (d_rem[j+1]),
      .out_dvd   (d_dvd[j+1]),
      .out_quo   (d_quo[j+1]),
      .out_len   (d_len[j+1])
    );
  end

  bas_back #(.AVOID_OFFSET(AVOID_OFFSET)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (d_v[ND]),
    .in_side     (d_side[ND]),
    .in_quo      (d_quo[ND]),
    .done        (done),
    .turn        (turn),
    .steer_angle (steer_angle),
    .bearing     (bearing)
  );

endmodule

// ===== rtl/bas_check.sv =====
// Port-level checker for the steering block and its bind.
module bas_check #(
  parameter int LAT = 61
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       turn,
  input logic [8:0] steer_angle,
  input logic [8:0] bearing
);

  // A result strobe traces back to a transfer a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LAT))
    else $error("result without matching command");

  // Bearing never exceeds a full turn
  a_bearing: assert property (@(posedge clk) disable iff (rst)
    done |-> bearing <= 9'd360)
    else $error("bearing out of range");

  // Holding course reports a wrapped heading
  a_hold: assert property (@(posedge clk) disable iff (rst)
    done && !turn |-> steer_angle < 9'd360)
    else $error("held heading out of range");

  // A steer of 360 only comes from aligning to a bearing of 360
  a_full: assert property (@(posedge clk) disable iff (rst)
    done && turn && steer_angle == 9'd360 |-> bearing == 9'd360)
    else $error("unwrapped steer angle");

endmodule

bind bearing_and_avoidance_steering bas_check #(.LAT(61)) u_bas_check (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .turn        (turn),
  .steer_angle (steer_angle),
  .bearing     (bearing)
);
